/* src/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and beat types of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PARTS     = 16;
    localparam int SIZE_BITS = 16;
    localparam int PART_W    = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CNT_W     = $clog2(PARTS + 1);
    localparam int WORD_W    = 2 * SIZE_BITS;

    // allocation modes
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;
    localparam logic [1:0] MODE_WORST = 2'd3;

    // request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [3:0] CFG_MODE   = 4'd0;
    localparam logic [3:0] CFG_NPARTS = 4'd1;

    // one table entry as it returns from the memory
    typedef struct packed {
        logic                 valid;
        logic [PART_W-1:0]    idx;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] free;
        logic                 busy;
    } ent_beat_t;

    // running choice of the scan
    typedef struct packed {
        logic                 found;
        logic [PART_W-1:0]    idx;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] free;
    } best_t;

endpackage

/* src/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/pfa_scan.sv */
// ----------------------------------------------------------------------------
// pfa_scan
// Fit selector: compares each entry beat against the running choice.
// ----------------------------------------------------------------------------
module pfa_scan
    import pfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 start,
    input  logic [1:0]           mode,
    input  logic [SIZE_BITS-1:0] amt,
    input  ent_beat_t            ent,
    output best_t                best
);

    best_t best_reg;
    best_t best_next;
    logic  elig;
    logic  take;

    always_comb begin
        elig = !ent.busy && (amt <= ent.size);
        case (mode)
            MODE_FIRST, MODE_NEXT: take = elig && !best_reg.found;
            MODE_BEST:  take = elig && (!best_reg.found || (ent.size < best_reg.size));
            MODE_WORST: take = (amt <= ent.free) &&
                               (!best_reg.found || (ent.free > best_reg.free));
            default:    take = 1'b0;
        endcase

        best_next = best_reg;
        if (start) begin
            best_next = '0;
        end else if (ent.valid && take) begin
            best_next.found = 1'b1;
            best_next.idx   = ent.idx;
            best_next.size  = ent.size;
            best_next.free  = ent.free;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

/* src/partition_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// partition_fit_allocator_unit
// Fixed-partition allocator: load, allocate (first/best/next/worst fit), clear.
// ----------------------------------------------------------------------------
// A load or unknown request goes to the finish step, which registers the
// result beat once the output is free. An allocate first scans the n
// partitions in use, one table read a cycle through the memory read port;
// a clear sweeps all PARTS entries (read, write-back). One request at a time.
// Reset: control, busy flags, free-space valid flags and rotor clear at once;
// partition sizes are undefined until loaded; no clearing pass.
module partition_fit_allocator_unit
    import pfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [3:0]  s_part_index,
    input  logic [15:0] s_amount_kb,
    input  logic [7:0]  s_job_id,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic [3:0]  m_chosen_part,
    output logic [15:0] m_free_after,
    output logic [7:0]  m_job_tag,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CLEAR, ST_FINISH} state_t;

    state_t               state_reg;
    logic [1:0]           req_reg;
    logic [3:0]           idx_reg;
    logic [SIZE_BITS-1:0] amt_reg;
    logic [7:0]           tag_reg;
    logic [1:0]           amode_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [PART_W-1:0]    start_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [PART_W-1:0]    pidx_reg;
    logic [PARTS-1:0]     busy_reg;
    logic [PARTS-1:0]     fsv_reg;
    logic [PART_W-1:0]    rotor_reg;
    logic [1:0]           mode_reg;
    logic [4:0]           nparts_reg;

    logic                 m_valid_reg;
    logic                 granted_reg;
    logic [3:0]           part_reg;
    logic [15:0]          free_reg;
    logic [7:0]           jtag_reg;

    logic                 s_acc;
    logic                 out_free;
    logic [CNT_W-1:0]     n_cur;
    logic [CNT_W:0]       scan_sum;
    logic [PART_W-1:0]    scan_addr;
    logic [CNT_W-1:0]     limit;
    logic                 ram_re;
    logic [PART_W-1:0]    ram_raddr;
    logic                 ram_we;
    logic [PART_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [SIZE_BITS-1:0] rd_size;
    logic [SIZE_BITS-1:0] rd_free;
    ent_beat_t            ent;
    best_t                best;
    logic                 load_ok;
    logic                 res_granted;
    logic [3:0]           res_part;
    logic [SIZE_BITS-1:0] res_free;
    logic [SIZE_BITS-1:0] free_new;
    logic [CNT_W-1:0]     rotor_inc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        n_cur = (int'(nparts_reg) > PARTS) ? CNT_W'(PARTS) : CNT_W'(nparts_reg);

        // circular scan order, starting at the latched rotor in next fit, else at entry 0
        scan_sum = {1'b0, CNT_W'(start_reg)} + {1'b0, cnt_reg};
        if (scan_sum >= {1'b0, n_reg}) begin
            scan_sum = scan_sum - {1'b0, n_reg};
        end
        scan_addr = PART_W'(scan_sum);

        limit     = (state_reg == ST_CLEAR) ? CNT_W'(PARTS) : n_reg;
        ram_re    = ((state_reg == ST_SCAN) || (state_reg == ST_CLEAR)) && (cnt_reg < limit);
        ram_raddr = (state_reg == ST_CLEAR) ? PART_W'(cnt_reg) : scan_addr;

        rd_size = ram_rdata[WORD_W-1:SIZE_BITS];
        rd_free = fsv_reg[pidx_reg] ? ram_rdata[SIZE_BITS-1:0] : '0;

        ent.valid = pend_reg && (state_reg == ST_SCAN);
        ent.idx   = pidx_reg;
        ent.size  = rd_size;
        ent.free  = rd_free;
        ent.busy  = busy_reg[pidx_reg];

        free_new  = (best.free >= amt_reg) ? (best.free - amt_reg) : '0;
        load_ok   = (int'(idx_reg) < PARTS);
        rotor_inc = CNT_W'(best.idx) + CNT_W'(1);

        res_granted = 1'b0;
        res_part    = '0;
        res_free    = '0;
        case (req_reg)
            REQ_LOAD: begin
                if (load_ok) begin
                    res_granted = 1'b1;
                    res_part    = idx_reg;
                    res_free    = amt_reg;
                end
            end
            REQ_CLEAR: res_granted = 1'b1;
            REQ_ALLOC: begin
                if (best.found) begin
                    res_granted = 1'b1;
                    res_part    = 4'(best.idx);
                    res_free    = free_new;
                end
            end
            default: res_granted = 1'b0;
        endcase

        // clear sweep writes each entry back in the cycle after its read
        ram_we    = 1'b0;
        ram_waddr = pidx_reg;
        ram_wdata = {rd_size, rd_size};
        if (state_reg == ST_CLEAR) begin
            ram_we = pend_reg;
        end else if ((state_reg == ST_FINISH) && out_free) begin
            if (req_reg == REQ_LOAD) begin
                ram_we    = load_ok;
                ram_waddr = PART_W'(idx_reg);
                ram_wdata = {amt_reg, amt_reg};
            end else if (req_reg == REQ_ALLOC) begin
                ram_we    = best.found;
                ram_waddr = best.idx;
                ram_wdata = {best.size, free_new};
            end
        end
    end

    pfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PARTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfa_scan u_scan (
        .aclk  (aclk),
        .start (s_acc),
        .mode  (amode_reg),
        .amt   (amt_reg),
        .ent   (ent),
        .best  (best)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            busy_reg    <= '0;
            fsv_reg     <= '0;
            rotor_reg   <= '0;
            mode_reg    <= MODE_FIRST;
            nparts_reg  <= 5'd16;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_MODE) begin
                    mode_reg <= cfg_wdata[1:0];
                end else if (cfg_index == CFG_NPARTS) begin
                    nparts_reg <= cfg_wdata;
                end
            end

            // the finish step reloads the result register itself
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            pend_reg <= ram_re;
            pidx_reg <= ram_raddr;
            if (ram_re) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        req_reg   <= s_req_type;
                        idx_reg   <= s_part_index;
                        amt_reg   <= SIZE_BITS'(s_amount_kb);
                        tag_reg   <= s_job_id;
                        amode_reg <= mode_reg;
                        n_reg     <= n_cur;
                        start_reg <= ((mode_reg == MODE_NEXT) && (CNT_W'(rotor_reg) < n_cur)) ?
                                     rotor_reg : '0;
                        cnt_reg   <= '0;
                        case (s_req_type)
                            REQ_ALLOC: state_reg <= ST_SCAN;
                            REQ_CLEAR: state_reg <= ST_CLEAR;
                            default:   state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_SCAN, ST_CLEAR: begin
                    // drain the last read before finishing
                    if (!ram_re && !pend_reg) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        granted_reg <= res_granted;
                        part_reg    <= res_part;
                        free_reg    <= 16'(res_free);
                        jtag_reg    <= tag_reg;
                        state_reg   <= ST_IDLE;
                        case (req_reg)
                            REQ_LOAD: begin
                                if (load_ok) begin
                                    busy_reg[PART_W'(idx_reg)] <= 1'b0;
                                    fsv_reg[PART_W'(idx_reg)]  <= 1'b1;
                                end
                            end
                            REQ_CLEAR: begin
                                busy_reg  <= '0;
                                fsv_reg   <= '1;
                                rotor_reg <= '0;
                            end
                            REQ_ALLOC: begin
                                if (best.found) begin
                                    busy_reg[best.idx] <= 1'b1;
                                    fsv_reg[best.idx]  <= 1'b1;
                                    if (amode_reg == MODE_NEXT) begin
                                        rotor_reg <= (rotor_inc >= n_reg) ?
                                                     '0 : PART_W'(rotor_inc);
                                    end
                                end
                            end
                            default: begin
                                // nothing changes
                            end
                        endcase
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_granted     = granted_reg;
    assign m_chosen_part = part_reg;
    assign m_free_after  = free_reg;
    assign m_job_tag     = jtag_reg;

endmodule

/* test/partition_fit_allocator_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partition_fit_allocator_unit_test
// Self-checking bench for the partition fit allocator. A scoreboard keeps its
// own copy of the partition table and predicts every result beat. The bench
// runs directed loads, allocations in all four fit modes and clears, then
// random phases across fit modes, partition counts and flow-control patterns.
// ----------------------------------------------------------------------------
module partition_fit_allocator_unit_test;
    import pfa_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [3:0] CFG_SPARE   = 4'd15;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [1:0]  req;
        logic [3:0]  part;
        logic [15:0] amount;
        logic [7:0]  job;
    } request_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  part;
        logic [15:0] free;
        logic [7:0]  tag;
    } grant_t;

    class alloc_tracker;
        logic [15:0] size_tab [PARTS];
        logic [15:0] free_tab [PARTS];
        bit          busy_tab [PARTS];
        int          rotor;
        logic [1:0]  mode;
        int          nparts;
        grant_t      grant_due_q [$];
        int          fails;

        function new();
            foreach (size_tab[k]) begin
                size_tab[k] = '0;
                free_tab[k] = '0;
                busy_tab[k] = 1'b0;
            end
            rotor  = 0;
            mode   = MODE_FIRST;
            nparts = PARTS;
            fails  = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [4:0] data);
            if (idx == CFG_MODE)
                mode = data[1:0];
            else if (idx == CFG_NPARTS)
                nparts = data;
        endfunction

        function int pending();
            return grant_due_q.size();
        endfunction

        // work out the grant for one accepted request and update the table
        function void place_request(request_t r);
            grant_t g;
            int     n, i, p, pick, start;
            bit     found;
            g.granted = 1'b0;
            g.part    = '0;
            g.free    = '0;
            g.tag     = r.job;
            n     = (nparts > PARTS) ? PARTS : nparts;
            found = 1'b0;
            pick  = 0;
            case (r.req)
                REQ_LOAD: begin
                    size_tab[r.part] = r.amount;
                    free_tab[r.part] = r.amount;
                    busy_tab[r.part] = 1'b0;
                    g.granted = 1'b1;
                    g.part    = r.part;
                    g.free    = r.amount;
                end
                REQ_CLEAR: begin
                    foreach (size_tab[k]) begin
                        free_tab[k] = size_tab[k];
                        busy_tab[k] = 1'b0;
                    end
                    rotor     = 0;
                    g.granted = 1'b1;
                end
                REQ_ALLOC: begin
                    if (mode == MODE_NEXT) begin
                        start = (rotor < n) ? rotor : 0;
                        for (i = 0; i < n && !found; i++) begin
                            p = (start + i) % n;
                            if (!busy_tab[p] && r.amount <= size_tab[p]) begin
                                pick  = p;
                                found = 1'b1;
                            end
                        end
                        if (found)
                            rotor = (pick + 1 >= n) ? 0 : pick + 1;
                    end else if (mode == MODE_WORST) begin
                        // busy flag ignored: largest remaining space wins
                        for (i = 0; i < n; i++) begin
                            if (r.amount <= free_tab[i] &&
                                (!found || free_tab[i] > free_tab[pick])) begin
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end else begin
                        for (i = 0; i < n && !(found && mode == MODE_FIRST); i++) begin
                            if (!busy_tab[i] && r.amount <= size_tab[i] &&
                                (!found ||
                                 (mode == MODE_BEST && size_tab[i] < size_tab[pick]))) begin
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        free_tab[pick] = (free_tab[pick] >= r.amount) ?
                                         free_tab[pick] - r.amount : '0;
                        busy_tab[pick] = 1'b1;
                        g.granted = 1'b1;
                        g.part    = pick[3:0];
                        g.free    = free_tab[pick];
                    end
                end
                default: ;
            endcase
            grant_due_q.push_back(g);
        endfunction

        function int field_diff(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(grant_t got);
            grant_t want;
            if (grant_due_q.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, tag %0d",
                         $time, got.tag);
                fails++;
                return;
            end
            want = grant_due_q.pop_front();
            fails += field_diff("granted", want.granted, got.granted);
            fails += field_diff("chosen_part", want.part, got.part);
            fails += field_diff("free_after", want.free, got.free);
            fails += field_diff("job_tag", want.tag, got.tag);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [3:0]  s_part_index;
    logic [15:0] s_amount_kb;
    logic [7:0]  s_job_id;
    logic        m_valid;
    logic        m_ready;
    logic        m_granted;
    logic [3:0]  m_chosen_part;
    logic [15:0] m_free_after;
    logic [7:0]  m_job_tag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [4:0]  cfg_wdata;

    alloc_tracker sb;
    idle_mode_e   idle;

    partition_fit_allocator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_part_index  (s_part_index),
        .s_amount_kb   (s_amount_kb),
        .s_job_id      (s_job_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted     (m_granted),
        .m_chosen_part (m_chosen_part),
        .m_free_after  (m_free_after),
        .m_job_tag     (m_job_tag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic request_t mk(logic [1:0] req, logic [3:0] part,
                                    logic [15:0] amt, logic [7:0] job);
        request_t r;
        r.req    = req;
        r.part   = part;
        r.amount = amt;
        r.job    = job;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick, sz;
        pick     = $urandom_range(99);
        r.part   = 4'($urandom_range(PARTS - 1));
        r.job    = 8'($urandom);
        sz       = $urandom_range(99);
        if (pick < 60) begin
            r.req = REQ_ALLOC;
            if (sz < 10)
                r.amount = sz[0] ? 16'hFFFF : 16'h0000;
            else if (sz < 60)
                r.amount = 16'($urandom_range(3000));
            else if (sz < 85)
                r.amount = 16'($urandom_range(20000));
            else
                r.amount = 16'($urandom);
        end else begin
            if (pick < 80)
                r.req = REQ_LOAD;
            else if (pick < 94)
                r.req = REQ_CLEAR;
            else
                r.req = REQ_UNKNOWN;
            // keep partition sizes mostly modest so jobs land often
            if (sz < 10)
                r.amount = sz[0] ? 16'hFFFF : 16'h0000;
            else if (sz < 50)
                r.amount = 16'($urandom_range(4000));
            else if (sz < 80)
                r.amount = 16'($urandom_range(30000));
            else
                r.amount = 16'($urandom);
        end
        return r;
    endfunction

    task automatic send_req(input request_t r);
        int gap;
        gap = (idle == IDLE_BOTH) ? 26 : 74;
        while ((idle == IDLE_SEND || idle == IDLE_BOTH) && $urandom_range(99) < gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= r.req;
        s_part_index <= r.part;
        s_amount_kb  <= r.amount;
        s_job_id     <= r.job;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.place_request(r);
    endtask

    // hold valid high when another write follows straight away
    task automatic write_cfg(input logic [3:0] idx, input logic [4:0] data, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // result side: check beats and throttle ready
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result({m_granted, m_chosen_part, m_free_after, m_job_tag});
            if (idle == IDLE_RECV)
                m_ready <= ($urandom_range(99) >= 74);
            else if (idle == IDLE_BOTH)
                m_ready <= ($urandom_range(99) >= 26);
            else
                m_ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("partition_fit_allocator_unit_test NOT OK");
        $finish;
    end

    initial begin
        logic [15:0] load_plan [PARTS];
        logic [4:0]  np_plan [12];
        logic [1:0]  mode_plan [4];
        logic [4:0]  np;
        int          i, ph;
        load_plan = '{16'd100, 16'd0, 16'hFFFF, 16'd500, 16'd100, 16'd2000, 16'd300,
                      16'd40000, 16'd1, 16'd800, 16'd100, 16'hFFFE, 16'd50, 16'd7000,
                      16'd250, 16'd1200};
        np_plan   = '{5'd16, 5'd5, 5'd16, 5'd1, 5'd0, 5'd31, 5'd12, 5'd16, 5'd17, 5'd3,
                      5'd16, 5'd9};
        mode_plan = '{MODE_FIRST, MODE_BEST, MODE_NEXT, MODE_WORST};
        sb   = new();
        idle = IDLE_NONE;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_LOAD;
        s_part_index <= '0;
        s_amount_kb  <= '0;
        s_job_id     <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_MODE;
        cfg_wdata    <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table before anything reads it
        for (i = 0; i < PARTS; i++)
            send_req(mk(REQ_LOAD, 4'(i), load_plan[i], 8'(i)));
        send_req(mk(REQ_ALLOC, 4'hF, 16'hFFFF, 8'hFF));
        send_req(mk(REQ_ALLOC, 4'h0, 16'h0000, 8'h00));
        send_req(mk(REQ_UNKNOWN, 4'h5, 16'h1234, 8'h11));
        send_req(mk(REQ_CLEAR, 4'hA, 16'h5555, 8'h22));

        drain();
        write_cfg(CFG_SPARE, 5'h1F, 1'b1);
        write_cfg(CFG_MODE, {3'b000, MODE_BEST}, 1'b0);
        send_req(mk(REQ_ALLOC, 4'h3, 16'd100, 8'h30));
        send_req(mk(REQ_ALLOC, 4'h3, 16'd60000, 8'h31));

        // next fit walks the rotor up, then a short table puts it out of range
        drain();
        write_cfg(CFG_MODE, {3'b000, MODE_NEXT}, 1'b0);
        for (i = 0; i < 3; i++)
            send_req(mk(REQ_ALLOC, 4'h7, 16'd7000, 8'(8'h40 + i)));
        drain();
        write_cfg(CFG_NPARTS, 5'd4, 1'b0);
        send_req(mk(REQ_ALLOC, 4'h7, 16'd0, 8'h50));

        drain();
        write_cfg(CFG_MODE, {3'b000, MODE_WORST}, 1'b1);
        write_cfg(CFG_NPARTS, 5'd16, 1'b0);
        send_req(mk(REQ_ALLOC, 4'h2, 16'd1000, 8'h60));
        send_req(mk(REQ_ALLOC, 4'h2, 16'd1000, 8'h61));

        for (ph = 0; ph < 12; ph++) begin
            drain();
            idle = idle_mode_e'(ph / 3);
            np   = (ph == 11) ? 5'($urandom_range(31)) : np_plan[ph];
            write_cfg(CFG_MODE, {3'b000, mode_plan[ph % 4]}, 1'b1);
            write_cfg(CFG_NPARTS, np, 1'b0);
            repeat (81) send_req(random_request());
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.fails == 0)
            $display("partition_fit_allocator_unit_test OK");
        else
            $display("partition_fit_allocator_unit_test NOT OK");
        $finish;
    end

endmodule
